// ===== hw/rtl/qrd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrd_pkg - shared types and constants for the quadrature rotation decoder
// Field widths, state and job codes, register indexes and the 4x
// transition rule.
// ----------------------------------------------------------------------------
package qrd_pkg;

    // field and register widths
    localparam int STEPS_W   = 12;
    localparam int PPT_W     = 8;
    localparam int PULSE_W   = 8;
    localparam int WHOLE_W   = 17;
    localparam int FRAC_W    = 21;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 12;

    // scaling constants
    localparam int DEGREES_PER_TURN = 360;
    localparam int MILLIONTHS       = 1000000;

    // divider sizing: widest dividend is remainder * one million
    localparam int DQ_W       = 32;
    localparam int CNT_W      = 6;
    localparam int PROD_W     = 16;   // |pulses| * degrees per turn
    localparam int TICK_BITS  = PULSE_W;
    localparam int WHOLE_BITS = PROD_W;
    localparam int FRAC_BITS  = DQ_W;
    localparam int FRAC_MAG_W = 20;   // quotient below one million

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEPS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PPT   = 1'b1;

    // reset value of pulses_per_tick
    localparam logic [PPT_W-1:0] PPT_RESET = 8'd4;

    // controller states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // divider jobs
    localparam logic [1:0] JOB_TICK  = 2'd0;
    localparam logic [1:0] JOB_WHOLE = 2'd1;
    localparam logic [1:0] JOB_FRAC  = 2'd2;

    // command codes
    localparam logic CMD_SAMPLE = 1'b0;

    typedef logic signed [WHOLE_W-1:0] whole_t;
    typedef logic signed [FRAC_W-1:0]  frac_t;
    typedef logic signed [1:0]         delta_t;

    // previous AB (bits 3:2) and new AB (bits 1:0) give -1, 0 or +1
    function automatic delta_t transition_delta(input logic [3:0] idx);
        delta_t d;
        case (idx)
            4'b0010, 4'b0100, 4'b1101, 4'b1011: d = -2'sd1;
            4'b0001, 4'b0111, 4'b1110, 4'b1000: d = 2'sd1;
            default:                            d = 2'sd0;
        endcase
        return d;
    endfunction

endpackage

// ===== hw/rtl/quadrature_rotation_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_rotation_decoder - 4x A/B encoder decoder with rotation readout
// Counts encoder pulses and reports degrees or legacy ticks on a rotation read.
// ----------------------------------------------------------------------------
// A pin sample is taken without a division when steps_per_turn is nonzero; in
// legacy mode (steps_per_turn zero) each sample's pulse count is also divided
// by pulses_per_tick, if that is nonzero. A read of the rotation channel in
// degree mode runs two back-to-back divisions by steps_per_turn (16 and 32
// quotient bits). All divisions share one restoring divider that produces one
// quotient bit per cycle. A finished result sits in an output register, so the
// next item is taken while it waits for its transfer.
// ----------------------------------------------------------------------------
module quadrature_rotation_decoder (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [qrd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [qrd_pkg::CFG_DAT_W-1:0]     cfg_data,
    // input channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              command,
    input  logic                              pin_a,
    input  logic                              pin_b,
    input  logic                              rotation_channel,
    // output channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [qrd_pkg::WHOLE_W-1:0] whole_part,
    output logic signed [qrd_pkg::FRAC_W-1:0]  fraction_part,
    output logic                              unsupported
);
    import qrd_pkg::*;

    // configuration
    logic [STEPS_W-1:0]       steps_reg;
    logic [PPT_W-1:0]         ppt_reg;

    // decoder state
    logic [1:0]               prev_ab_reg, prev_ab_next;
    logic signed [PULSE_W-1:0] pulse_reg, pulse_next;
    logic signed [PULSE_W-1:0] tick_reg, tick_next;
    delta_t                   last_delta_reg, last_delta_next;

    // controller and divider
    logic [1:0]               state_reg, state_next;
    logic [1:0]               job_reg, job_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [DQ_W-1:0]          dq_reg, dq_next;
    logic [STEPS_W-1:0]       rem_reg, rem_next;
    logic [STEPS_W-1:0]       divisor_reg, divisor_next;
    logic                     sign_reg, sign_next;

    // staged result and output register
    whole_t                   res_whole_reg, res_whole_next;
    frac_t                    res_frac_reg, res_frac_next;
    logic                     res_unsup_reg, res_unsup_next;
    logic                     out_valid_reg, out_valid_next;
    whole_t                   out_whole_reg, out_whole_next;
    frac_t                    out_frac_reg, out_frac_next;
    logic                     out_unsup_reg, out_unsup_next;

    logic                     in_fire;
    delta_t                   delta;
    logic signed [PULSE_W-1:0] pulse_sum;
    logic [PULSE_W-1:0]       sum_mag;
    logic [PULSE_W-1:0]       pulse_mag;
    logic [PROD_W-1:0]        prod_mag;
    logic [STEPS_W:0]         trial;
    logic [STEPS_W:0]         diff;
    logic                     qbit;
    logic [DQ_W-1:0]          frac_dividend;
    logic [PROD_W:0]          whole_mag;
    logic [FRAC_W-1:0]        frac_mag;

    assign in_ready      = (state_reg == ST_IDLE);
    assign in_fire       = in_valid && in_ready;
    assign out_valid     = out_valid_reg;
    assign whole_part    = out_whole_reg;
    assign fraction_part = out_frac_reg;
    assign unsupported   = out_unsup_reg;

    // transition rule and pulse update
    assign delta     = transition_delta({prev_ab_reg, pin_a, pin_b});
    assign pulse_sum = pulse_reg + {{(PULSE_W-2){delta[1]}}, delta};
    assign sum_mag   = pulse_sum[PULSE_W-1] ? PULSE_W'(~pulse_sum + 8'sd1)
                                            : PULSE_W'(pulse_sum);
    assign pulse_mag = pulse_reg[PULSE_W-1] ? PULSE_W'(~pulse_reg + 8'sd1)
                                            : PULSE_W'(pulse_reg);
    assign prod_mag  = PROD_W'(PROD_W'(pulse_mag) * PROD_W'(DEGREES_PER_TURN));

    // one restoring division step
    assign trial = {rem_reg, dq_reg[DQ_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign qbit  = (trial >= {1'b0, divisor_reg});

    // second dividend: remainder of the degree division times one million
    assign frac_dividend = DQ_W'(DQ_W'(rem_reg) * DQ_W'(MILLIONTHS));
    assign whole_mag     = {1'b0, dq_reg[PROD_W-1:0]};
    assign frac_mag      = {1'b0, dq_reg[FRAC_MAG_W-1:0]};

    // next-state logic
    always_comb
    begin
        prev_ab_next    = prev_ab_reg;
        pulse_next      = pulse_reg;
        tick_next       = tick_reg;
        last_delta_next = last_delta_reg;
        state_next      = state_reg;
        job_next        = job_reg;
        cnt_next        = cnt_reg;
        dq_next         = dq_reg;
        rem_next        = rem_reg;
        divisor_next    = divisor_reg;
        sign_next       = sign_reg;
        res_whole_next  = res_whole_reg;
        res_frac_next   = res_frac_reg;
        res_unsup_next  = res_unsup_reg;
        out_whole_next  = out_whole_reg;
        out_frac_next   = out_frac_reg;
        out_unsup_next  = out_unsup_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (command == CMD_SAMPLE)
                    begin
                        prev_ab_next = {pin_a, pin_b};
                        pulse_next   = pulse_sum;
                        if (steps_reg == '0)
                        begin
                            last_delta_next = delta;
                            // legacy mode: split pulses into ticks and remainder
                            if (ppt_reg != '0)
                            begin
                                sign_next    = pulse_sum[PULSE_W-1];
                                dq_next      = {sum_mag, {(DQ_W-PULSE_W){1'b0}}};
                                rem_next     = '0;
                                divisor_next = STEPS_W'(ppt_reg);
                                cnt_next     = CNT_W'(TICK_BITS);
                                job_next     = JOB_TICK;
                                state_next   = ST_DIV;
                            end
                        end
                    end
                    else if (!rotation_channel)
                    begin
                        res_whole_next = '0;
                        res_frac_next  = '0;
                        res_unsup_next = 1'b1;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        pulse_next     = '0;
                        res_unsup_next = 1'b0;
                        if (steps_reg != '0)
                        begin
                            // degree mode: |pulses| * 360 / steps
                            sign_next    = pulse_reg[PULSE_W-1];
                            dq_next      = {prod_mag, {(DQ_W-PROD_W){1'b0}}};
                            rem_next     = '0;
                            divisor_next = steps_reg;
                            cnt_next     = CNT_W'(WHOLE_BITS);
                            job_next     = JOB_WHOLE;
                            state_next   = ST_DIV;
                        end
                        else
                        begin
                            res_whole_next = whole_t'(tick_reg);
                            res_frac_next  = frac_t'(last_delta_reg);
                            state_next     = ST_DONE;
                        end
                    end
                end
            end

            ST_DIV:
            begin
                if (cnt_reg != '0)
                begin
                    dq_next  = {dq_reg[DQ_W-2:0], qbit};
                    rem_next = qbit ? diff[STEPS_W-1:0] : trial[STEPS_W-1:0];
                    cnt_next = cnt_reg - 1'b1;
                end
                else
                begin
                    case (job_reg)
                        JOB_TICK:
                        begin
                            tick_next  = sign_reg ? -$signed(dq_reg[PULSE_W-1:0])
                                                  : $signed(dq_reg[PULSE_W-1:0]);
                            pulse_next = sign_reg ? -$signed(rem_reg[PULSE_W-1:0])
                                                  : $signed(rem_reg[PULSE_W-1:0]);
                            state_next = ST_IDLE;
                        end
                        JOB_WHOLE:
                        begin
                            res_whole_next = sign_reg ? -$signed(whole_mag)
                                                      : $signed(whole_mag);
                            dq_next        = frac_dividend;
                            rem_next       = '0;
                            cnt_next       = CNT_W'(FRAC_BITS);
                            job_next       = JOB_FRAC;
                        end
                        JOB_FRAC:
                        begin
                            res_frac_next = sign_reg ? -$signed(frac_mag)
                                                     : $signed(frac_mag);
                            state_next    = ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_DONE:
            begin
                // move the result once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_whole_next = res_whole_reg;
                    out_frac_next  = res_frac_reg;
                    out_unsup_next = res_unsup_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg <= '0;
            ppt_reg   <= PPT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_STEPS: steps_reg <= cfg_data[STEPS_W-1:0];
                REG_PPT:   ppt_reg   <= cfg_data[PPT_W-1:0];
                default:   steps_reg <= steps_reg;
            endcase
        end
    end

    // control and decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_ab_reg    <= '0;
            pulse_reg      <= '0;
            tick_reg       <= '0;
            last_delta_reg <= '0;
            state_reg      <= ST_IDLE;
            job_reg        <= JOB_TICK;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            prev_ab_reg    <= prev_ab_next;
            pulse_reg      <= pulse_next;
            tick_reg       <= tick_next;
            last_delta_reg <= last_delta_next;
            state_reg      <= state_next;
            job_reg        <= job_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        dq_reg        <= dq_next;
        rem_reg       <= rem_next;
        divisor_reg   <= divisor_next;
        sign_reg      <= sign_next;
        res_whole_reg <= res_whole_next;
        res_frac_reg  <= res_frac_next;
        res_unsup_reg <= res_unsup_next;
        out_whole_reg <= out_whole_next;
        out_frac_reg  <= out_frac_next;
        out_unsup_reg <= out_unsup_next;
    end

endmodule
